// ===== src/headway_zone_throttle_controller_top_assert.svh =====
// assertion macros for the headway zone throttle controller
`ifndef HEADWAY_ZONE_THROTTLE_CONTROLLER_TOP_ASSERT_SVH
`define HEADWAY_ZONE_THROTTLE_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication
`define HZTC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define HZTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/hztc_pkg.sv =====
package hztc_pkg;

    localparam int DIST_W   = 8;
    localparam int TIME_W   = 32;
    localparam int SPEED_W  = 16;
    localparam int GAP_W    = 16;
    localparam int POWER_W  = 8;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 3;
    localparam int ZONE_W   = 3;
    localparam int DVD_W    = 22;
    localparam int DIV_STEPS = DVD_W;
    localparam int CNT_W    = $clog2(DIV_STEPS);
    localparam int SCALE    = 10000;

    localparam int DEF_MIN_CONVERT_SPEED_MM_S = 100;
    localparam int DEF_MIN_FOLLOW_DISTANCE_CM = 10;

    localparam logic [GAP_W-1:0]   RST_MAX_GAP   = 16'd3000;
    localparam logic [GAP_W-1:0]   RST_MIN_GAP   = 16'd1000;
    localparam logic [GAP_W-1:0]   RST_DES_GAP   = 16'd2000;
    localparam logic [GAP_W-1:0]   RST_GAP_TOL   = 16'd300;
    localparam logic [POWER_W-1:0] RST_INIT_PWR  = 8'hBA;
    localparam logic [7:0]         RST_PWR_STEP  = 8'd5;
    localparam logic [7:0]         RST_TRIM_INT  = 8'd10;
    localparam logic [POWER_W-1:0] RST_TRIM_LIM  = 8'hCE;

    typedef enum logic [IDX_W-1:0] {
        REG_MAX_GAP   = 3'd0,
        REG_MIN_GAP   = 3'd1,
        REG_DES_GAP   = 3'd2,
        REG_GAP_TOL   = 3'd3,
        REG_INIT_PWR  = 3'd4,
        REG_PWR_STEP  = 3'd5,
        REG_TRIM_INT  = 3'd6,
        REG_TRIM_LIM  = 3'd7
    } t_reg_idx;

    typedef enum logic [ZONE_W-1:0] {
        ZONE_A = 3'd0,
        ZONE_B = 3'd1,
        ZONE_C = 3'd2,
        ZONE_D = 3'd3,
        ZONE_E = 3'd4
    } t_zone;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HLOAD,
        S_HDIV,
        S_LLOAD,
        S_LDIV,
        S_DECIDE
    } t_state;

    typedef struct packed {
        logic cap;
        logic h_load;
        logic l_load;
        logic div_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_status;

endpackage

// ===== src/hztc_in_if.sv =====
interface hztc_in_if;
    logic                            valid;
    logic                            ready;
    logic [hztc_pkg::DIST_W-1:0]     distance_cm;
    logic [hztc_pkg::TIME_W-1:0]     timestamp_ms;
    logic [hztc_pkg::SPEED_W-1:0]    own_speed_mm_s;

    modport source(output valid, distance_cm, timestamp_ms, own_speed_mm_s, input ready);
    modport sink(input valid, distance_cm, timestamp_ms, own_speed_mm_s, output ready);
endinterface

// ===== src/hztc_out_if.sv =====
interface hztc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [hztc_pkg::POWER_W-1:0] motor_power;
    logic                               motor_update;
    logic [hztc_pkg::ZONE_W-1:0]        zone;
    logic [hztc_pkg::GAP_W-1:0]         headway_ms;
    logic signed [hztc_pkg::SPEED_W-1:0] lead_speed_mm_s;

    modport source(output valid, motor_power, motor_update, zone, headway_ms,
        lead_speed_mm_s, input ready);
    modport sink(input valid, motor_power, motor_update, zone, headway_ms,
        lead_speed_mm_s, output ready);
endinterface

// ===== src/headway_zone_throttle_controller_top.sv =====
// flow: the input transaction is captured, then two 22-step serial divisions (headway, then
// lead speed) run on one shared restoring divider, each after its load, then the decide step
// a new input is taken only after the last commit; a waiting result does not block the next input
// reset: synchronous active-low i_rst_n restores register defaults, throttle to -70 and
// clears the sample history and trim counter
module headway_zone_throttle_controller_top #(
    parameter int MIN_CONVERT_SPEED_MM_S = hztc_pkg::DEF_MIN_CONVERT_SPEED_MM_S,
    parameter int MIN_FOLLOW_DISTANCE_CM = hztc_pkg::DEF_MIN_FOLLOW_DISTANCE_CM
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [hztc_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [hztc_pkg::CFG_W-1:0]   i_cfg_data,
    hztc_in_if.sink                      i_in,
    hztc_out_if.source                   o_out
);
    hztc_pkg::t_cmd    w_cmd;
    hztc_pkg::t_status w_status;

    hztc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    hztc_datapath #(
        .MIN_CONVERT_SPEED_MM_S (MIN_CONVERT_SPEED_MM_S),
        .MIN_FOLLOW_DISTANCE_CM (MIN_FOLLOW_DISTANCE_CM)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_distance_cm     (i_in.distance_cm),
        .i_timestamp_ms    (i_in.timestamp_ms),
        .i_own_speed_mm_s  (i_in.own_speed_mm_s),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_motor_power     (o_out.motor_power),
        .o_motor_update    (o_out.motor_update),
        .o_zone            (o_out.zone),
        .o_headway_ms      (o_out.headway_ms),
        .o_lead_speed_mm_s (o_out.lead_speed_mm_s)
    );
endmodule

// ===== src/hztc_div.sv =====
module hztc_div (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic                          i_step,
    input  logic [hztc_pkg::DVD_W-1:0]    i_dividend,
    input  logic [hztc_pkg::TIME_W-1:0]   i_divisor,
    output logic [hztc_pkg::DVD_W-1:0]    o_quotient
);
    localparam int DW = hztc_pkg::DVD_W;
    localparam int VW = hztc_pkg::TIME_W;

    logic [VW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_quo, n_quo;
    logic [VW-1:0] r_dvs;
    logic [VW:0]   w_trial;
    logic [VW:0]   w_diff;

    always_comb begin
        w_trial = {r_rem, r_quo[DW-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        n_rem   = r_rem;
        n_quo   = r_quo;
        if (i_load) begin
            n_rem = '0;
            n_quo = i_dividend;
        end else if (i_step) begin
            if (!w_diff[VW]) begin
                n_rem = w_diff[VW-1:0];
                n_quo = {r_quo[DW-2:0], 1'b1};
            end else begin
                n_rem = w_trial[VW-1:0];
                n_quo = {r_quo[DW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_load) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_quotient = r_quo;
endmodule

// ===== src/hztc_ctrl.sv =====
module hztc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  hztc_pkg::t_status  i_status,
    output hztc_pkg::t_cmd     o_cmd
);
    localparam int CW = hztc_pkg::CNT_W;

    hztc_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hztc_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            hztc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = hztc_pkg::S_HLOAD;
                end
            end
            hztc_pkg::S_HLOAD: begin
                o_cmd.h_load = 1'b1;
                n_cnt        = '0;
                n_state      = hztc_pkg::S_HDIV;
            end
            hztc_pkg::S_HDIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CW'(hztc_pkg::DIV_STEPS - 1)) begin
                    n_state = hztc_pkg::S_LLOAD;
                end
            end
            hztc_pkg::S_LLOAD: begin
                o_cmd.l_load = 1'b1;
                n_cnt        = '0;
                n_state      = hztc_pkg::S_LDIV;
            end
            hztc_pkg::S_LDIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CW'(hztc_pkg::DIV_STEPS - 1)) begin
                    n_state = hztc_pkg::S_DECIDE;
                end
            end
            hztc_pkg::S_DECIDE: begin
                if (!i_status.out_full) begin
                    o_cmd.commit = 1'b1;
                    n_state      = hztc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hztc_pkg::S_IDLE;
            end
        endcase
    end
endmodule

// ===== src/hztc_datapath.sv =====
module hztc_datapath #(
    parameter int MIN_CONVERT_SPEED_MM_S = hztc_pkg::DEF_MIN_CONVERT_SPEED_MM_S,
    parameter int MIN_FOLLOW_DISTANCE_CM = hztc_pkg::DEF_MIN_FOLLOW_DISTANCE_CM
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [hztc_pkg::IDX_W-1:0]           i_cfg_idx,
    input  logic [hztc_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic [hztc_pkg::DIST_W-1:0]          i_distance_cm,
    input  logic [hztc_pkg::TIME_W-1:0]          i_timestamp_ms,
    input  logic [hztc_pkg::SPEED_W-1:0]         i_own_speed_mm_s,
    input  hztc_pkg::t_cmd                       i_cmd,
    output hztc_pkg::t_status                    o_status,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [hztc_pkg::POWER_W-1:0]  o_motor_power,
    output logic                                 o_motor_update,
    output logic [hztc_pkg::ZONE_W-1:0]          o_zone,
    output logic [hztc_pkg::GAP_W-1:0]           o_headway_ms,
    output logic signed [hztc_pkg::SPEED_W-1:0]  o_lead_speed_mm_s
);
    localparam int DW = hztc_pkg::DVD_W;
    localparam int TW = hztc_pkg::TIME_W;
    localparam int SW = hztc_pkg::SPEED_W;
    localparam int PW = hztc_pkg::POWER_W;

    // configuration
    logic [15:0]          r_max_gap, r_min_gap, r_des_gap, r_gap_tol;
    logic signed [PW-1:0] r_init_pwr, r_trim_lim;
    logic [7:0]           r_pwr_step, r_trim_int;

    // controller state
    logic                 r_have;
    logic [7:0]           r_older, r_newer;
    logic [TW-1:0]        r_prev_time;
    logic signed [PW-1:0] r_throttle;
    logic [7:0]           r_hold;

    // captured transaction
    logic [7:0]           r_dist;
    logic [TW-1:0]        r_time;
    logic [SW-1:0]        r_speed;
    logic [15:0]          r_h;
    logic                 r_dt_zero;
    logic                 r_neg;

    // output register
    logic                 r_out_valid;
    logic signed [PW-1:0] r_o_power;
    logic                 r_o_update;
    logic [2:0]           r_o_zone;
    logic [15:0]          r_o_h;
    logic signed [SW-1:0] r_o_lead;

    logic [DW-1:0]        w_dvd;
    logic [TW-1:0]        w_dvs;
    logic [DW-1:0]        w_quo;
    logic [TW-1:0]        w_dt;
    logic [7:0]           w_absdiff;

    function automatic logic signed [7:0] f_clamp(input logic signed [11:0] v,
                                                  input logic signed [7:0] lim);
        logic signed [7:0] res;
        if (v > 12'sd0) begin
            res = '0;
        end else if (v < 12'(lim)) begin
            res = lim;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

    function automatic logic signed [7:0] f_step(input logic signed [7:0] thr,
                                                 input logic up,
                                                 input logic [7:0] ps,
                                                 input logic signed [7:0] lim);
        logic signed [8:0]  tm1;
        logic signed [2:0]  q;
        logic signed [11:0] prod;
        logic signed [11:0] sum;
        tm1 = 9'(thr) - 9'sd1;
        if (tm1 < -9'sd100) begin
            q = -3'sd2;
        end else if (tm1 < 9'sd0) begin
            q = -3'sd1;
        end else if (tm1 < 9'sd100) begin
            q = 3'sd0;
        end else begin
            q = 3'sd1;
        end
        prod = 12'(12'(q) * $signed({4'b0, ps}));
        sum  = up ? (12'(thr) + prod) : (12'(thr) - prod);
        return f_clamp(sum, lim);
    endfunction

    hztc_div u_div (
        .i_clk      (i_clk),
        .i_load     (i_cmd.h_load | i_cmd.l_load),
        .i_step     (i_cmd.div_step),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_quotient (w_quo)
    );

    assign w_dt      = r_time - r_prev_time;
    assign w_absdiff = (r_dist >= r_older) ? (r_dist - r_older) : (r_older - r_dist);

    always_comb begin
        w_dvd = '0;
        w_dvs = '0;
        if (i_cmd.h_load) begin
            if (r_speed > SW'(MIN_CONVERT_SPEED_MM_S)) begin
                w_dvd = DW'(r_dist) * DW'(hztc_pkg::SCALE);
                w_dvs = TW'(r_speed);
            end else begin
                w_dvs = TW'(SW'(MIN_CONVERT_SPEED_MM_S));
                if (r_dist > 8'(MIN_FOLLOW_DISTANCE_CM)) begin
                    w_dvd = DW'(r_dist) * DW'(hztc_pkg::SCALE);
                end
            end
        end else begin
            w_dvd = DW'(w_absdiff) * DW'(hztc_pkg::SCALE);
            w_dvs = w_dt;
        end
    end

    // decision
    logic                 w_first;
    logic [7:0]           w_old_e, w_new_e;
    logic signed [23:0]   w_lead_full;
    logic signed [SW-1:0] w_lead;
    logic signed [17:0]   w_lo, w_hi, w_h18;
    logic                 w_fast;
    hztc_pkg::t_zone      w_zone;
    logic signed [PW-1:0] w_thr;
    logic signed [PW-1:0] w_power;
    logic                 w_update;
    logic [7:0]           w_hold;
    logic [7:0]           w_hold_inc;

    always_comb begin
        w_first = ~r_have;
        w_old_e = w_first ? r_dist : r_older;
        w_new_e = w_first ? r_newer : r_dist;
        if (w_first) begin
            w_lead_full = '0;
        end else if (r_dt_zero) begin
            w_lead_full = 24'(r_speed);
        end else if (r_neg) begin
            w_lead_full = 24'(r_speed) - 24'(w_quo);
        end else begin
            w_lead_full = 24'(r_speed) + 24'(w_quo);
        end
        if (w_lead_full > 24'sd32767) begin
            w_lead = 16'sh7FFF;
        end else if (w_lead_full < -24'sd32768) begin
            w_lead = 16'sh8000;
        end else begin
            w_lead = w_lead_full[15:0];
        end

        w_lo   = $signed({2'b0, r_des_gap}) - $signed({2'b0, r_gap_tol});
        w_hi   = $signed({2'b0, r_des_gap}) + $signed({2'b0, r_gap_tol});
        w_h18  = $signed({2'b0, r_h});
        w_fast = 18'(w_lead) > $signed({2'b0, r_speed});

        w_thr      = r_throttle;
        w_update   = 1'b0;
        w_hold     = r_hold;
        w_hold_inc = r_hold + 8'd1;
        w_power    = r_throttle;
        if (r_h > r_max_gap) begin
            w_zone   = hztc_pkg::ZONE_A;
            w_power  = r_init_pwr;
            w_update = 1'b1;
        end else if (r_h < r_min_gap) begin
            w_zone   = hztc_pkg::ZONE_E;
            w_thr    = f_step(r_throttle, 1'b0, r_pwr_step, r_init_pwr);
            w_power  = w_thr;
            w_update = 1'b1;
        end else begin
            if (w_fast) begin
                w_zone = (w_lo > w_h18 && $signed({2'b0, r_min_gap}) < w_h18) ?
                    hztc_pkg::ZONE_D : hztc_pkg::ZONE_C;
            end else begin
                w_zone = (w_hi >= w_h18 && w_lo <= w_h18) ?
                    hztc_pkg::ZONE_C : hztc_pkg::ZONE_B;
            end
            case (w_zone)
                hztc_pkg::ZONE_D: begin
                    w_thr    = f_step(r_throttle, 1'b0, r_pwr_step, r_init_pwr);
                    w_update = 1'b1;
                end
                hztc_pkg::ZONE_B: begin
                    w_thr    = f_step(r_throttle, 1'b1, r_pwr_step, r_init_pwr);
                    w_update = 1'b1;
                end
                default: begin
                    w_hold = w_hold_inc;
                    if (w_hold_inc > r_trim_int) begin
                        w_hold = '0;
                        if (r_throttle <= r_trim_lim) begin
                            if (w_old_e > w_new_e) begin
                                w_thr    = f_clamp(12'(r_throttle) - 12'sd1, r_init_pwr);
                                w_update = 1'b1;
                            end else if (w_old_e < w_new_e) begin
                                w_thr    = f_clamp(12'(r_throttle) + 12'sd1, r_init_pwr);
                                w_update = 1'b1;
                            end
                        end
                    end
                end
            endcase
            w_power = w_thr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_gap   <= hztc_pkg::RST_MAX_GAP;
            r_min_gap   <= hztc_pkg::RST_MIN_GAP;
            r_des_gap   <= hztc_pkg::RST_DES_GAP;
            r_gap_tol   <= hztc_pkg::RST_GAP_TOL;
            r_init_pwr  <= hztc_pkg::RST_INIT_PWR;
            r_pwr_step  <= hztc_pkg::RST_PWR_STEP;
            r_trim_int  <= hztc_pkg::RST_TRIM_INT;
            r_trim_lim  <= hztc_pkg::RST_TRIM_LIM;
            r_have      <= 1'b0;
            r_older     <= '0;
            r_newer     <= '0;
            r_prev_time <= '0;
            r_throttle  <= hztc_pkg::RST_INIT_PWR;
            r_hold      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (hztc_pkg::t_reg_idx'(i_cfg_idx))
                    hztc_pkg::REG_MAX_GAP:  r_max_gap  <= i_cfg_data;
                    hztc_pkg::REG_MIN_GAP:  r_min_gap  <= i_cfg_data;
                    hztc_pkg::REG_DES_GAP:  r_des_gap  <= i_cfg_data;
                    hztc_pkg::REG_GAP_TOL:  r_gap_tol  <= i_cfg_data;
                    hztc_pkg::REG_INIT_PWR: r_init_pwr <= i_cfg_data[7:0];
                    hztc_pkg::REG_PWR_STEP: r_pwr_step <= i_cfg_data[7:0];
                    hztc_pkg::REG_TRIM_INT: r_trim_int <= i_cfg_data[7:0];
                    hztc_pkg::REG_TRIM_LIM: r_trim_lim <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                r_have      <= 1'b1;
                r_prev_time <= r_time;
                r_newer     <= w_new_e;
                r_older     <= (w_zone == hztc_pkg::ZONE_A || w_zone == hztc_pkg::ZONE_E) ?
                    w_old_e : w_new_e;
                r_throttle  <= w_thr;
                r_hold      <= w_hold;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_dist  <= i_distance_cm;
            r_time  <= i_timestamp_ms;
            r_speed <= i_own_speed_mm_s;
        end
        if (i_cmd.l_load) begin
            r_h       <= (w_quo > DW'(16'hFFFF)) ? 16'hFFFF : w_quo[15:0];
            r_dt_zero <= (w_dt == '0);
            r_neg     <= (r_dist < r_older);
        end
        if (i_cmd.commit) begin
            r_o_power  <= w_power;
            r_o_update <= w_update;
            r_o_zone   <= w_zone;
            r_o_h      <= r_h;
            r_o_lead   <= w_lead;
        end
    end

    assign o_status.out_full = r_out_valid & ~i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_motor_power     = r_o_power;
    assign o_motor_update    = r_o_update;
    assign o_zone            = r_o_zone;
    assign o_headway_ms      = r_o_h;
    assign o_lead_speed_mm_s = r_o_lead;
endmodule

// ===== src/hztc_checker.sv =====
`include "headway_zone_throttle_controller_top_assert.svh"

module hztc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_motor_update,
    input logic [2:0] i_zone
);
    `HZTC_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    `HZTC_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready)
    `HZTC_ASSERT_NOW(a_zone_range, i_out_valid, i_zone <= 3'd4)
    `HZTC_ASSERT_NOW(a_far_cmd, i_out_valid && i_zone == 3'd0, i_motor_update)
endmodule

bind headway_zone_throttle_controller_top hztc_checker u_hztc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_motor_update (o_out.motor_update),
    .i_zone         (o_out.zone)
);

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PW  = hztc_pkg::POWER_W;
    localparam int GW  = hztc_pkg::GAP_W;
    localparam int SPW = hztc_pkg::SPEED_W;
    localparam int TW  = hztc_pkg::TIME_W;
    localparam int DW  = hztc_pkg::DIST_W;
    localparam int CW  = hztc_pkg::CFG_W;
    localparam int ZW  = hztc_pkg::ZONE_W;

    typedef struct {
        logic signed [PW-1:0]  power;
        logic                  update;
        hztc_pkg::t_zone       zone;
        logic [GW-1:0]         headway;
        logic signed [SPW-1:0] lead;
    } t_motor_cmd;

    class headway_scoreboard;
        int max_gap, min_gap, des_gap, gap_tol;
        int init_pwr, pwr_step, trim_int, trim_lim;
        bit have_sample;
        int older_dist, newer_dist;
        logic [TW-1:0] prev_time;
        int throttle, hold_count;
        t_motor_cmd pending_cmds[$];
        int errors, matched;

        function void reset_state();
            max_gap = 3000; min_gap = 1000; des_gap = 2000; gap_tol = 300;
            init_pwr = -70; pwr_step = 5; trim_int = 10; trim_lim = -50;
            have_sample = 0; older_dist = 0; newer_dist = 0; prev_time = 0;
            throttle = -70; hold_count = 0;
            errors = 0; matched = 0;
        endfunction

        function void write_reg(hztc_pkg::t_reg_idx idx, logic [CW-1:0] val);
            case (idx)
                hztc_pkg::REG_MAX_GAP:  max_gap = int'(val);
                hztc_pkg::REG_MIN_GAP:  min_gap = int'(val);
                hztc_pkg::REG_DES_GAP:  des_gap = int'(val);
                hztc_pkg::REG_GAP_TOL:  gap_tol = int'(val);
                hztc_pkg::REG_INIT_PWR: init_pwr = int'($signed(val[7:0]));
                hztc_pkg::REG_PWR_STEP: pwr_step = int'(val[7:0]);
                hztc_pkg::REG_TRIM_INT: trim_int = int'(val[7:0]);
                hztc_pkg::REG_TRIM_LIM: trim_lim = int'($signed(val[7:0]));
                default: ;
            endcase
        endfunction

        function int clamp(int v);
            if (v > 0) return 0;
            if (v < init_pwr) return init_pwr;
            return v;
        endfunction

        function void step_throttle(int sign);
            int a, q;
            a = throttle - 1;
            q = (a >= 0) ? a / 100 : -((-a + 99) / 100);
            throttle = clamp(throttle + sign * q * pwr_step);
        endfunction

        function void note_input(logic [DW-1:0] d, logic [TW-1:0] t,
                                 logic [SPW-1:0] s);
            int h, lo, hi, spd;
            longint v, mag, dt;
            logic [TW-1:0] dt32;
            int diff;
            t_motor_cmd c;
            spd = int'(s);
            if (spd > hztc_pkg::DEF_MIN_CONVERT_SPEED_MM_S)
                h = d * hztc_pkg::SCALE / spd;
            else if (d > hztc_pkg::DEF_MIN_FOLLOW_DISTANCE_CM)
                h = d * hztc_pkg::SCALE / hztc_pkg::DEF_MIN_CONVERT_SPEED_MM_S;
            else h = 0;
            if (h > 65535) h = 65535;
            v = 0;
            if (!have_sample) begin
                older_dist = int'(d);
                have_sample = 1;
            end else begin
                newer_dist = int'(d);
                dt32 = t - prev_time;
                dt = longint'(dt32);
                if (dt == 0) begin
                    v = spd;
                end else begin
                    diff = newer_dist - older_dist;
                    mag = longint'(diff < 0 ? -diff : diff) * hztc_pkg::SCALE / dt;
                    v = (diff < 0 ? -mag : mag) + spd;
                end
            end
            prev_time = t;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            lo = des_gap - gap_tol;
            hi = des_gap + gap_tol;
            c.update = 1'b0;
            if (h > max_gap) begin
                c.zone = hztc_pkg::ZONE_A;
                c.power = PW'(init_pwr);
                c.update = 1'b1;
            end else if (h < min_gap) begin
                c.zone = hztc_pkg::ZONE_E;
                step_throttle(-1);
                c.power = PW'(throttle);
                c.update = 1'b1;
            end else begin
                if (v > spd)
                    c.zone = (lo > h && min_gap < h) ? hztc_pkg::ZONE_D : hztc_pkg::ZONE_C;
                else
                    c.zone = (hi >= h && lo <= h) ? hztc_pkg::ZONE_C : hztc_pkg::ZONE_B;
                if (c.zone == hztc_pkg::ZONE_D) begin
                    step_throttle(-1);
                    c.update = 1'b1;
                end else if (c.zone == hztc_pkg::ZONE_B) begin
                    step_throttle(1);
                    c.update = 1'b1;
                end else begin
                    hold_count = (hold_count + 1) & 255;
                    if (hold_count > trim_int) begin
                        if (throttle <= trim_lim) begin
                            if (older_dist > newer_dist) begin
                                throttle = clamp(throttle - 1);
                                c.update = 1'b1;
                            end else if (older_dist < newer_dist) begin
                                throttle = clamp(throttle + 1);
                                c.update = 1'b1;
                            end
                        end
                        hold_count = 0;
                    end
                end
                c.power = PW'(throttle);
                older_dist = newer_dist;
            end
            c.headway = GW'(h);
            c.lead = SPW'(v);
            pending_cmds.push_back(c);
        endfunction

        function void report(string field, longint e, longint a);
            errors++;
            $display("%0t mismatch %s expected %0d actual %0d", $time, field, e, a);
        endfunction

        function void check_result(logic signed [PW-1:0] p, logic u,
                                   logic [ZW-1:0] z, logic [GW-1:0] h,
                                   logic signed [SPW-1:0] l);
            t_motor_cmd c;
            if (pending_cmds.size() == 0) begin
                errors++;
                $display("%0t unexpected result transaction, expected none actual zone %0d",
                         $time, z);
                return;
            end
            c = pending_cmds.pop_front();
            matched++;
            if (p !== c.power) report("motor_power", c.power, p);
            if (u !== c.update) report("motor_update", c.update, u);
            if (z !== c.zone) report("zone", c.zone, z);
            if (h !== c.headway) report("headway_ms", c.headway, h);
            if (l !== c.lead) report("lead_speed_mm_s", c.lead, l);
        endfunction
    endclass

    logic i_clk, i_rst_n, i_cfg_we;
    logic [hztc_pkg::IDX_W-1:0] i_cfg_idx;
    logic [CW-1:0] i_cfg_data;

    hztc_in_if  sample_ch();
    hztc_out_if cmd_ch();

    headway_zone_throttle_controller_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in(sample_ch.sink), .o_out(cmd_ch.source)
    );

    headway_scoreboard sb;
    int src_idle, snk_idle;
    int walk_dist;
    logic [TW-1:0] clock_ms;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("headway_zone_throttle_controller_top test failed");
        $finish;
    end

    initial begin
        cmd_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && cmd_ch.valid && cmd_ch.ready)
                sb.check_result(cmd_ch.motor_power, cmd_ch.motor_update, cmd_ch.zone,
                                cmd_ch.headway_ms, cmd_ch.lead_speed_mm_s);
            cmd_ch.ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    task automatic send_sample(logic [DW-1:0] d, logic [TW-1:0] t,
                               logic [SPW-1:0] s);
        while ($urandom_range(99) < src_idle) begin
            sample_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.distance_cm <= d;
        sample_ch.timestamp_ms <= t;
        sample_ch.own_speed_mm_s <= s;
        do @(posedge i_clk); while (!sample_ch.ready);
        sb.note_input(d, t, s);
    endtask

    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        while (sb.pending_cmds.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(hztc_pkg::t_reg_idx idx, logic [CW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic write_all(int mx, int mn, int ds, int tl, int ip, int ps, int ti, int tm);
        write_reg(hztc_pkg::REG_MAX_GAP, CW'(mx));
        write_reg(hztc_pkg::REG_MIN_GAP, CW'(mn));
        write_reg(hztc_pkg::REG_DES_GAP, CW'(ds));
        write_reg(hztc_pkg::REG_GAP_TOL, CW'(tl));
        write_reg(hztc_pkg::REG_INIT_PWR, CW'(ip & 8'hFF));
        write_reg(hztc_pkg::REG_PWR_STEP, CW'(ps));
        write_reg(hztc_pkg::REG_TRIM_INT, CW'(ti));
        write_reg(hztc_pkg::REG_TRIM_LIM, CW'(tm & 8'hFF));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random(int n);
        int r, target, spd;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 70) begin
                walk_dist += $urandom_range(10) - 5;
                if (walk_dist < 0) walk_dist = 0;
                if (walk_dist > 255) walk_dist = 255;
            end else begin
                walk_dist = $urandom_range(255);
            end
            r = $urandom_range(99);
            if (r < 80) clock_ms += $urandom_range(200, 20);
            else if (r < 88) clock_ms += 0;
            else if (r < 95) clock_ms += $urandom_range(3, 1);
            else clock_ms = $urandom;
            r = $urandom_range(99);
            if (r < 75) begin
                target = $urandom_range(4000, 500);
                spd = walk_dist * hztc_pkg::SCALE / target;
                if (spd > 65535) spd = 65535;
            end else if (r < 90) begin
                spd = $urandom_range(200);
            end else begin
                spd = $urandom_range(65535);
            end
            if (k == n / 2 && n > 100) wait_drained();
            send_sample(DW'(walk_dist), clock_ms, SPW'(spd));
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        src_idle = 32;
        snk_idle = 74;
        walk_dist = 120;
        clock_ms = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= hztc_pkg::REG_MAX_GAP;
        i_cfg_data <= '0;
        sample_ch.valid <= 1'b0;
        sample_ch.distance_cm <= '0;
        sample_ch.timestamp_ms <= '0;
        sample_ch.own_speed_mm_s <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: headway and lead speed corners
        send_sample(8'd0, 32'd0, 16'd0);
        send_sample(8'd255, 32'd1, 16'd0);
        send_sample(8'd0, 32'd2, 16'd0);
        send_sample(8'd255, 32'd2, 16'd65535);
        send_sample(8'd10, 32'd100, 16'd100);
        send_sample(8'd11, 32'd200, 16'd101);
        send_sample(8'd100, 32'hFFFF_FFF0, 16'd500);
        send_sample(8'd90, 32'h0000_0010, 16'd500);
        send_sample(8'd100, 32'h0000_0010, 16'd600);
        send_sample(8'd150, 32'h0000_0100, 16'd30000);
        for (int k = 0; k < 14; k++)
            send_sample(DW'(100 + (k % 3)), TW'(32'h200 + k * 100), 16'd500);
        clock_ms = 32'h1000;
        send_random(276);
        wait_drained();

        write_all(65535, 0, 0, 65535, -100, 255, 255, 100);
        send_random(300);
        wait_drained();

        src_idle = 74;
        snk_idle = 32;
        write_all(0, 65535, 65535, 0, 100, 0, 0, -100);
        send_random(150);
        wait_drained();
        write_all(2500, 1500, 2000, 200, -30, 1, 0, 0);
        send_random(300);
        wait_drained();

        src_idle = 0;
        snk_idle = 0;
        write_all($urandom_range(4000, 2000), $urandom_range(1500, 500),
                  $urandom_range(2500, 1500), $urandom_range(600), -$urandom_range(100),
                  $urandom_range(20), $urandom_range(5), -$urandom_range(100));
        send_random(500);
        wait_drained();

        $display("covered %0d results over five register settings incl. extremes,",
                 sb.matched);
        $display("directed headway/lead corners, time wrap, zero time step, mixed stalls");
        if (sb.errors == 0 && sb.pending_cmds.size() == 0) begin
            $display("headway_zone_throttle_controller_top test passed");
        end else begin
            $display("headway_zone_throttle_controller_top test failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/hztc_pkg.sv
src/hztc_in_if.sv
src/hztc_out_if.sv
src/hztc_div.sv
src/hztc_ctrl.sv
src/hztc_datapath.sv
src/headway_zone_throttle_controller_top.sv
src/hztc_checker.sv
sim/tb.sv
